/* rtl/stg_pkg.sv */
// stg_pkg: shared types, codes and constants of the sine tone generator
// depends on nothing; every other file imports it

package stg_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_RATE_SELECT   = 2'd0;
   localparam logic [1:0] CSR_CHANNEL_COUNT = 2'd1;
   localparam logic [1:0] CSR_RUNNING       = 2'd2;

   // sample rate codes, anything else selects 48 kHz
   localparam logic [1:0] RATE_CODE_8K  = 2'd0;
   localparam logic [1:0] RATE_CODE_16K = 2'd1;

   localparam int RATE_8K_HZ  = 8000;
   localparam int RATE_16K_HZ = 16000;
   localparam int RATE_48K_HZ = 48000;

   localparam logic [15:0] TONE_HZ   = 16'd440;
   localparam logic [13:0] AMPLITUDE = 14'd9830;
   localparam int          FRAC_BITS = 30;

   // round(2*pi*2^30)
   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

   // shared multiplier operand width and reciprocal division range
   localparam int OPER_W   = 36;
   localparam int HALF_W   = OPER_W / 2;
   localparam int ACC_W    = 2 * OPER_W;
   localparam int DIV_BITS = 34;

   // angle = |f| * quot + (|f| * rem) / rate, quot and rem of 2*pi*2^30 by rate
   localparam logic [63:0] QUOT_8K  = TWO_PI_Q30 / 64'(RATE_8K_HZ);
   localparam logic [63:0] QUOT_16K = TWO_PI_Q30 / 64'(RATE_16K_HZ);
   localparam logic [63:0] QUOT_48K = TWO_PI_Q30 / 64'(RATE_48K_HZ);
   localparam logic [63:0] REM_8K   = TWO_PI_Q30 % 64'(RATE_8K_HZ);
   localparam logic [63:0] REM_16K  = TWO_PI_Q30 % 64'(RATE_16K_HZ);
   localparam logic [63:0] REM_48K  = TWO_PI_Q30 % 64'(RATE_48K_HZ);

   // reciprocals: floor(a / d) = (a * m) >> s for a below 2^DIV_BITS
   localparam int SHIFT_8K  = DIV_BITS + $clog2(RATE_8K_HZ);
   localparam int SHIFT_16K = DIV_BITS + $clog2(RATE_16K_HZ);
   localparam int SHIFT_48K = DIV_BITS + $clog2(RATE_48K_HZ);
   localparam logic [63:0] RECIP_8K  = (64'd1 << SHIFT_8K)  / 64'(RATE_8K_HZ)  + 64'd1;
   localparam logic [63:0] RECIP_16K = (64'd1 << SHIFT_16K) / 64'(RATE_16K_HZ) + 64'd1;
   localparam logic [63:0] RECIP_48K = (64'd1 << SHIFT_48K) / 64'(RATE_48K_HZ) + 64'd1;

   // series divisors 2n(2n+1) for n = 1..8
   localparam int TAYLOR_MAX   = 8;
   localparam int TAYLOR_IDX_W = $clog2(TAYLOR_MAX);

   localparam logic [OPER_W-1:0] TAYLOR_RECIP [0:TAYLOR_MAX-1] = '{
      OPER_W'((64'd1 << (DIV_BITS + $clog2(6)))   / 64'd6   + 64'd1),
      OPER_W'((64'd1 << (DIV_BITS + $clog2(20)))  / 64'd20  + 64'd1),
      OPER_W'((64'd1 << (DIV_BITS + $clog2(42)))  / 64'd42  + 64'd1),
      OPER_W'((64'd1 << (DIV_BITS + $clog2(72)))  / 64'd72  + 64'd1),
      OPER_W'((64'd1 << (DIV_BITS + $clog2(110))) / 64'd110 + 64'd1),
      OPER_W'((64'd1 << (DIV_BITS + $clog2(156))) / 64'd156 + 64'd1),
      OPER_W'((64'd1 << (DIV_BITS + $clog2(210))) / 64'd210 + 64'd1),
      OPER_W'((64'd1 << (DIV_BITS + $clog2(272))) / 64'd272 + 64'd1)
   };

   localparam logic [5:0] TAYLOR_SHIFT [0:TAYLOR_MAX-1] = '{
      6'(DIV_BITS + $clog2(6)),
      6'(DIV_BITS + $clog2(20)),
      6'(DIV_BITS + $clog2(42)),
      6'(DIV_BITS + $clog2(72)),
      6'(DIV_BITS + $clog2(110)),
      6'(DIV_BITS + $clog2(156)),
      6'(DIV_BITS + $clog2(210)),
      6'(DIV_BITS + $clog2(272))
   };

   // one accepted request as it travels from front to back
   typedef struct packed {
      logic        stopped;
      logic        last_frame;
      logic [15:0] phase;
      logic [1:0]  rate_code;
      logic        two_ch;
   } cmd_type;

   // back end sequencer
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL_LO,
      BK_MUL_HI,
      BK_WRITE,
      BK_EMIT
   } back_state_type;

   // products computed by the shared multiplier, in order
   typedef enum logic [2:0] {
      OP_X_QUOT,
      OP_X_REM,
      OP_X_DIV,
      OP_SQUARE,
      OP_Q_DIV,
      OP_TERM,
      OP_SCALE
   } op_type;

   function automatic logic [15:0] rate_hz(input logic [1:0] code);
      unique case (code)
         RATE_CODE_8K:  rate_hz = 16'(RATE_8K_HZ);
         RATE_CODE_16K: rate_hz = 16'(RATE_16K_HZ);
         default:       rate_hz = 16'(RATE_48K_HZ);
      endcase
   endfunction

   function automatic logic [OPER_W-1:0] rate_quot(input logic [1:0] code);
      unique case (code)
         RATE_CODE_8K:  rate_quot = OPER_W'(QUOT_8K);
         RATE_CODE_16K: rate_quot = OPER_W'(QUOT_16K);
         default:       rate_quot = OPER_W'(QUOT_48K);
      endcase
   endfunction

   function automatic logic [OPER_W-1:0] rate_rem(input logic [1:0] code);
      unique case (code)
         RATE_CODE_8K:  rate_rem = OPER_W'(REM_8K);
         RATE_CODE_16K: rate_rem = OPER_W'(REM_16K);
         default:       rate_rem = OPER_W'(REM_48K);
      endcase
   endfunction

   function automatic logic [OPER_W-1:0] rate_recip(input logic [1:0] code);
      unique case (code)
         RATE_CODE_8K:  rate_recip = OPER_W'(RECIP_8K);
         RATE_CODE_16K: rate_recip = OPER_W'(RECIP_16K);
         default:       rate_recip = OPER_W'(RECIP_48K);
      endcase
   endfunction

   function automatic logic [5:0] rate_shift(input logic [1:0] code);
      unique case (code)
         RATE_CODE_8K:  rate_shift = 6'(SHIFT_8K);
         RATE_CODE_16K: rate_shift = 6'(SHIFT_16K);
         default:       rate_shift = 6'(SHIFT_48K);
      endcase
   endfunction

endpackage

/* rtl/sine_tone_generator.sv */
// The back end evaluates one frame at a time on the single shared 36x18 multiplier,
// which takes two passes and a writeback for each of 5+2*TAYLOR_TERMS products; the
// two-entry request queue holds further requests meanwhile. A request while stopped
// skips the multiplier and goes from idle straight to emitting its result.
// Reset: rate_select 16 kHz, one channel, stream stopped, phase zero, request queue and result register empty.

module sine_tone_generator
   import stg_pkg::*;
#(
   parameter int TAYLOR_TERMS = 6
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_restart,
   input  logic               req_last_frame,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [14:0] rsp_sample,
   output logic               rsp_channel,
   output logic               rsp_frame_end,
   output logic               rsp_read_end,
   output logic               rsp_not_running,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [1:0]         csr_data
);

   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_empty;
   cmd_type q_cmd_push;
   cmd_type q_cmd_pop;

   // intake, registers and phase
   stg_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_restart    (req_restart),
      .req_last_frame (req_last_frame),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .q_push         (q_push),
      .q_cmd          (q_cmd_push),
      .q_full         (q_full)
   );

   // request queue
   stg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_cmd_push),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_cmd_pop),
      .empty     (q_empty)
   );

   // sine evaluation and results
   stg_back #(
      .TAYLOR_TERMS (TAYLOR_TERMS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_cmd           (q_cmd_pop),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_sample      (rsp_sample),
      .rsp_channel     (rsp_channel),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_read_end    (rsp_read_end),
      .rsp_not_running (rsp_not_running)
   );

endmodule

/* rtl/stg_front.sv */
// stg_front: request intake, configuration registers and phase counter
// depends on stg_pkg; feeds stg_queue with one cmd_type per request

module stg_front
   import stg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_restart,
   input  logic       req_last_frame,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [1:0] csr_data,
   output logic       q_push,
   output cmd_type    q_cmd,
   input  logic       q_full
);

   logic [1:0]  rate_sel_ff, rate_sel_in;
   logic [1:0]  chan_cnt_ff, chan_cnt_in;
   logic        running_ff, running_in;
   logic [15:0] phase_ff, phase_in;

   logic [15:0] rate_now;
   logic [15:0] phase_red;
   logic        accept;
   logic        start;
   logic [15:0] phase_use;
   logic [16:0] phase_adv;
   logic [16:0] phase_wrap;

   // the stored phase stays as written; it is brought below the current rate on use
   assign rate_now  = rate_hz(rate_sel_ff);
   assign req_full  = q_full;
   assign accept    = req_push & ~req_full;
   assign csr_ready = 1'b1;

   assign start = csr_valid && (csr_index == CSR_RUNNING) && csr_data[0] && !running_ff;

   // phase modulo the current rate, compares against fixed multiples of the rate
   always_comb begin
      phase_red = phase_ff;
      unique case (rate_sel_ff)
         RATE_CODE_8K: begin
            if (phase_ff >= 16'(5 * RATE_8K_HZ)) begin
               phase_red = phase_ff - 16'(5 * RATE_8K_HZ);
            end else if (phase_ff >= 16'(4 * RATE_8K_HZ)) begin
               phase_red = phase_ff - 16'(4 * RATE_8K_HZ);
            end else if (phase_ff >= 16'(3 * RATE_8K_HZ)) begin
               phase_red = phase_ff - 16'(3 * RATE_8K_HZ);
            end else if (phase_ff >= 16'(2 * RATE_8K_HZ)) begin
               phase_red = phase_ff - 16'(2 * RATE_8K_HZ);
            end else if (phase_ff >= 16'(RATE_8K_HZ)) begin
               phase_red = phase_ff - 16'(RATE_8K_HZ);
            end
         end
         RATE_CODE_16K: begin
            if (phase_ff >= 16'(2 * RATE_16K_HZ)) begin
               phase_red = phase_ff - 16'(2 * RATE_16K_HZ);
            end else if (phase_ff >= 16'(RATE_16K_HZ)) begin
               phase_red = phase_ff - 16'(RATE_16K_HZ);
            end
         end
         default: ;
      endcase
   end

   // phase for this frame and the one after it
   assign phase_use  = req_restart ? 16'd0 : phase_red;
   assign phase_adv  = {1'b0, phase_use} + 17'(TONE_HZ);
   assign phase_wrap = (phase_adv >= {1'b0, rate_now}) ? phase_adv - {1'b0, rate_now}
                                                       : phase_adv;

   // register writes
   always_comb begin
      rate_sel_in = rate_sel_ff;
      chan_cnt_in = chan_cnt_ff;
      running_in  = running_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RATE_SELECT:   rate_sel_in = csr_data;
            CSR_CHANNEL_COUNT: chan_cnt_in = csr_data;
            CSR_RUNNING:       running_in  = csr_data[0];
            default: ;
         endcase
      end
   end

   // phase counter update, cleared on stream start; a stopped stream otherwise only clears it on restart
   always_comb begin
      phase_in = phase_ff;
      if (start) begin
         phase_in = 16'd0;
      end else if (accept) begin
         if (running_ff) begin
            phase_in = phase_wrap[15:0];
         end else if (req_restart) begin
            phase_in = 16'd0;
         end
      end
   end

   // request handed to the back end
   assign q_push           = accept;
   assign q_cmd.stopped    = ~running_ff;
   assign q_cmd.last_frame = req_last_frame;
   assign q_cmd.phase      = phase_use;
   assign q_cmd.rate_code  = rate_sel_ff;
   assign q_cmd.two_ch     = chan_cnt_ff[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_sel_ff <= RATE_CODE_16K;
         chan_cnt_ff <= 2'd1;
         running_ff  <= 1'b0;
         phase_ff    <= 16'd0;
      end else begin
         rate_sel_ff <= rate_sel_in;
         chan_cnt_ff <= chan_cnt_in;
         running_ff  <= running_in;
         phase_ff    <= phase_in;
      end
   end

   // phase never leaves the range of the fastest rate
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff < 16'(RATE_48K_HZ))
      else $error("phase counter out of range");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      start |=> phase_ff == 16'd0)
      else $error("phase not cleared on stream start");

   a_phase_moves: assert property (@(posedge clock) disable iff (reset)
      accept && running_ff && !req_restart && !start |=> phase_ff != $past(phase_ff))
      else $error("phase did not advance on a running frame");

endmodule

/* rtl/stg_queue.sv */
// stg_queue: two-entry request queue between front and back end
// depends on stg_pkg for cmd_type

module stg_queue
   import stg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   localparam int DEPTH = 2;

   cmd_type    entry_ff [0:DEPTH-1];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push_ok;
   logic       pop_ok;

   assign full     = (count_ff == 2'(DEPTH));
   assign empty    = (count_ff == 2'd0);
   assign push_ok  = push & ~full;
   assign pop_ok   = pop & ~empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 2'd1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(DEPTH))
      else $error("queue count overflow");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      empty |-> rd_ptr_ff == wr_ptr_ff)
      else $error("empty queue with unequal pointers");

   a_full_ptrs: assert property (@(posedge clock) disable iff (reset)
      full |-> rd_ptr_ff == wr_ptr_ff)
      else $error("full queue with unequal pointers");

endmodule

/* rtl/stg_back.sv */
// stg_back: sine evaluation on one shared 36x18 multiplier and result register
// depends on stg_pkg; takes requests from stg_queue

module stg_back
   import stg_pkg::*;
#(
   parameter int TAYLOR_TERMS = 6
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  cmd_type           q_cmd,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic signed [14:0] rsp_sample,
   output logic              rsp_channel,
   output logic              rsp_frame_end,
   output logic              rsp_read_end,
   output logic              rsp_not_running
);

   localparam int N_W = (TAYLOR_TERMS > 1) ? $clog2(TAYLOR_TERMS) : 1;
   localparam logic [N_W-1:0] N_LAST = N_W'(TAYLOR_TERMS - 1);

   // control
   back_state_type state_ff, state_in;
   op_type         op_ff, op_in;
   logic [N_W-1:0] n_ff, n_in;
   logic           ch_ff, ch_in;
   logic           out_valid_ff, out_valid_in;

   // request fields and working values
   logic               err_ff, err_in;
   logic               last_ff, last_in;
   logic [1:0]         rate_ff, rate_in;
   logic               two_ff, two_in;
   logic [14:0]        f_mag_ff, f_mag_in;
   logic               f_neg_ff, f_neg_in;
   logic [31:0]        x_mag_ff, x_mag_in;
   logic [30:0]        rem_ff, rem_in;
   logic [33:0]        x2_ff, x2_in;
   logic [30:0]        q_ff, q_in;
   logic [32:0]        term_mag_ff, term_mag_in;
   logic               term_neg_ff, term_neg_in;
   logic signed [34:0] sum_ff, sum_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [14:0] sample_ff, sample_in;

   // result register
   logic signed [14:0] out_sample_ff, out_sample_in;
   logic               out_channel_ff, out_channel_in;
   logic               out_frame_end_ff, out_frame_end_in;
   logic               out_read_end_ff, out_read_end_in;
   logic               out_not_running_ff, out_not_running_in;

   // datapath nets
   logic [OPER_W-1:0]       op_a, op_b;
   logic [HALF_W-1:0]       op_b_half;
   logic [OPER_W+HALF_W-1:0] prod;
   logic [TAYLOR_IDX_W-1:0] n_idx;
   logic [34:0]             sum_mag;
   logic [15:0]             cmd_rate;
   logic [16:0]             cmd_dbl;
   logic [31:0]             x_full;
   logic [32:0]             term_next;
   logic                    term_neg_next;
   logic [17:0]             scaled;
   logic [13:0]             scaled_clamp;
   logic                    out_free;
   logic                    pop_ok;
   logic                    emit_end;

   assign n_idx    = TAYLOR_IDX_W'(n_ff);
   assign sum_mag  = sum_ff[34] ? 35'(-sum_ff) : 35'(sum_ff);
   assign cmd_rate = rate_hz(q_cmd.rate_code);
   assign cmd_dbl  = {q_cmd.phase, 1'b0};
   assign pop_ok   = rsp_pop & out_valid_ff;
   assign out_free = ~out_valid_ff | rsp_pop;
   assign emit_end = err_ff | (ch_ff == two_ff);

   // operand selection for the current product
   always_comb begin
      case (op_ff)
         OP_X_QUOT: begin
            op_a = OPER_W'(f_mag_ff);
            op_b = rate_quot(rate_ff);
         end
         OP_X_REM: begin
            op_a = OPER_W'(f_mag_ff);
            op_b = rate_rem(rate_ff);
         end
         OP_X_DIV: begin
            op_a = OPER_W'(rem_ff);
            op_b = rate_recip(rate_ff);
         end
         OP_SQUARE: begin
            op_a = OPER_W'(x_mag_ff);
            op_b = OPER_W'(x_mag_ff);
         end
         OP_Q_DIV: begin
            op_a = OPER_W'(x2_ff);
            op_b = TAYLOR_RECIP[n_idx];
         end
         OP_TERM: begin
            op_a = OPER_W'(term_mag_ff);
            op_b = OPER_W'(q_ff);
         end
         OP_SCALE: begin
            op_a = OPER_W'(sum_mag);
            op_b = OPER_W'(AMPLITUDE);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // shared multiplier, low half of op_b first and high half second
   assign op_b_half = (state_ff == BK_MUL_HI) ? op_b[OPER_W-1:HALF_W] : op_b[HALF_W-1:0];
   assign prod      = (OPER_W+HALF_W)'(op_a) * (OPER_W+HALF_W)'(op_b_half);

   // writeback values
   assign x_full        = x_mag_ff + 32'(acc_ff >> rate_shift(rate_ff));
   assign term_next     = 33'(acc_ff >> FRAC_BITS);
   assign term_neg_next = ~term_neg_ff;
   assign scaled        = acc_ff[FRAC_BITS+17:FRAC_BITS];
   assign scaled_clamp  = (scaled > 18'(AMPLITUDE)) ? AMPLITUDE : scaled[13:0];

   // sequencer
   always_comb begin
      state_in           = state_ff;
      op_in              = op_ff;
      n_in               = n_ff;
      ch_in              = ch_ff;
      err_in             = err_ff;
      last_in            = last_ff;
      rate_in            = rate_ff;
      two_in             = two_ff;
      f_mag_in           = f_mag_ff;
      f_neg_in           = f_neg_ff;
      x_mag_in           = x_mag_ff;
      rem_in             = rem_ff;
      x2_in              = x2_ff;
      q_in               = q_ff;
      term_mag_in        = term_mag_ff;
      term_neg_in        = term_neg_ff;
      sum_in             = sum_ff;
      acc_in             = acc_ff;
      sample_in          = sample_ff;
      q_pop              = 1'b0;
      out_valid_in       = pop_ok ? 1'b0 : out_valid_ff;
      out_sample_in      = out_sample_ff;
      out_channel_in     = out_channel_ff;
      out_frame_end_in   = out_frame_end_ff;
      out_read_end_in    = out_read_end_ff;
      out_not_running_in = out_not_running_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               err_in  = q_cmd.stopped;
               last_in = q_cmd.last_frame;
               rate_in = q_cmd.rate_code;
               two_in  = q_cmd.two_ch;
               ch_in   = 1'b0;
               // fold phase into [-rate/2, rate/2)
               if (cmd_dbl >= {1'b0, cmd_rate}) begin
                  f_neg_in = 1'b1;
                  f_mag_in = 15'(cmd_rate - q_cmd.phase);
               end else begin
                  f_neg_in = 1'b0;
                  f_mag_in = 15'(q_cmd.phase);
               end
               op_in    = OP_X_QUOT;
               state_in = q_cmd.stopped ? BK_EMIT : BK_MUL_LO;
            end
         end
         BK_MUL_LO: begin
            acc_in   = ACC_W'(prod);
            state_in = BK_MUL_HI;
         end
         BK_MUL_HI: begin
            acc_in   = acc_ff + {prod, {HALF_W{1'b0}}};
            state_in = BK_WRITE;
         end
         BK_WRITE: begin
            state_in = BK_MUL_LO;
            case (op_ff)
               OP_X_QUOT: begin
                  x_mag_in = acc_ff[31:0];
                  op_in    = OP_X_REM;
               end
               OP_X_REM: begin
                  rem_in = acc_ff[30:0];
                  op_in  = OP_X_DIV;
               end
               OP_X_DIV: begin
                  x_mag_in    = x_full;
                  term_mag_in = 33'(x_full);
                  term_neg_in = f_neg_ff;
                  sum_in      = f_neg_ff ? -$signed({3'b000, x_full})
                                         : $signed({3'b000, x_full});
                  op_in       = OP_SQUARE;
               end
               OP_SQUARE: begin
                  x2_in = 34'(acc_ff >> FRAC_BITS);
                  n_in  = '0;
                  op_in = OP_Q_DIV;
               end
               OP_Q_DIV: begin
                  q_in  = 31'(acc_ff >> TAYLOR_SHIFT[n_idx]);
                  op_in = OP_TERM;
               end
               OP_TERM: begin
                  term_mag_in = term_next;
                  term_neg_in = term_neg_next;
                  sum_in      = term_neg_next ? sum_ff - $signed({2'b00, term_next})
                                              : sum_ff + $signed({2'b00, term_next});
                  if (n_ff == N_LAST) begin
                     op_in = OP_SCALE;
                  end else begin
                     n_in  = n_ff + 1'b1;
                     op_in = OP_Q_DIV;
                  end
               end
               OP_SCALE: begin
                  sample_in = sum_ff[34] ? $signed(15'd0 - {1'b0, scaled_clamp})
                                         : $signed({1'b0, scaled_clamp});
                  state_in  = BK_EMIT;
               end
               default: ;
            endcase
         end
         BK_EMIT: begin
            // one result per channel into the output register, a single one for a stopped stream
            if (out_free) begin
               out_valid_in       = 1'b1;
               out_sample_in      = err_ff ? 15'sd0 : sample_ff;
               out_channel_in     = ch_ff;
               out_frame_end_in   = emit_end;
               out_read_end_in    = emit_end & (err_ff | last_ff);
               out_not_running_in = err_ff;
               if (emit_end) begin
                  state_in = BK_IDLE;
               end else begin
                  ch_in = 1'b1;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         op_ff        <= OP_X_QUOT;
         n_ff         <= '0;
         ch_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         n_ff         <= n_in;
         ch_ff        <= ch_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath and result payload
   always_ff @(posedge clock) begin
      err_ff             <= err_in;
      last_ff            <= last_in;
      rate_ff            <= rate_in;
      two_ff             <= two_in;
      f_mag_ff           <= f_mag_in;
      f_neg_ff           <= f_neg_in;
      x_mag_ff           <= x_mag_in;
      rem_ff             <= rem_in;
      x2_ff              <= x2_in;
      q_ff               <= q_in;
      term_mag_ff        <= term_mag_in;
      term_neg_ff        <= term_neg_in;
      sum_ff             <= sum_in;
      acc_ff             <= acc_in;
      sample_ff          <= sample_in;
      out_sample_ff      <= out_sample_in;
      out_channel_ff     <= out_channel_in;
      out_frame_end_ff   <= out_frame_end_in;
      out_read_end_ff    <= out_read_end_in;
      out_not_running_ff <= out_not_running_in;
   end

   assign rsp_empty       = ~out_valid_ff;
   assign rsp_sample      = out_sample_ff;
   assign rsp_channel     = out_channel_ff;
   assign rsp_frame_end   = out_frame_end_ff;
   assign rsp_read_end    = out_read_end_ff;
   assign rsp_not_running = out_not_running_ff;

   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_sample_ff <= 15'sd9830) && (out_sample_ff >= -15'sd9830))
      else $error("sample outside amplitude");

   a_stopped_result: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_not_running_ff |->
         out_sample_ff == 15'sd0 && out_frame_end_ff && out_read_end_ff)
      else $error("malformed stopped-stream result");

   a_read_end_frame: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_read_end_ff |-> out_frame_end_ff)
      else $error("read end without frame end");

   a_second_channel: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_channel_ff |-> !out_not_running_ff && out_frame_end_ff)
      else $error("bad second channel result");

endmodule
